// ===== rtl/core/mcpd_pkg.sv =====
// Package with widths, defaults and register codes of the multi-channel port debouncer.
package mcpd_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_CHANNELS    = 8;
   localparam int DEF_VALUE_WIDTH = 8;

   // Fixed field widths of the stream words and the configuration port.
   localparam int CHANNEL_W   = 3;
   localparam int SAMPLE_W    = 8;
   localparam int MASK_W      = 8;
   localparam int THRESH_W    = 64;
   localparam int COUNT_W     = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 1;

   // Match counter saturation value.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCAN_ENABLE_MASK  = 1'b0,
      CSR_FILTER_THRESHOLDS = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/core/multi_channel_port_debouncer.sv =====
// Top level of the multi-channel port debouncer with its per-channel state memory.
//
// Usage: each word on the req_ channel carries one port sample for one channel.
// The block returns exactly one word on the rsp_ channel per accepted word, in order:
// the channel, its debounced stable value, a change flag and its tracking flag. The csr_
// port writes the scan enable mask (index 0) and the packed 8-bit match thresholds
// (index 1); the user must write only while the block is idle, not enforced by the block.
//
// A word accepted into the read stage moves to the output register once that
// register is free or drains, and rsp_tvalid rises with it. Throughput is one
// word per cycle while the receiver does not stall: the channel state sits in
// one memory read at acceptance and is written back when the word leaves the
// read stage, and the last write is forwarded to a read of the same channel
// that overlaps it.
//
// Reset clears the registers, the pipeline and one valid flag per channel; a
// channel that was never written reads as all zero, so no clearing pass runs.
// When the receiver stalls, the result stays in the output register, one more
// word waits in the read stage, and req_tready drops until the output drains.
module multi_channel_port_debouncer
   import mcpd_pkg::*;
#(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // Sample channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [2:0] channel, [10:3] sample
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [2:0] out_channel, [10:3] debounced value,
                                              // [11] changed, [12] tracking
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_wdata
);

   // Memory geometry: one entry per channel holding {tracking, counter, candidate, stable}.
   localparam int ADDR_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STABLE_LO = 0;
   localparam int CAND_LO   = VALUE_WIDTH;
   localparam int COUNT_LO  = 2 * VALUE_WIDTH;
   localparam int TRACK_BIT = 2 * VALUE_WIDTH + COUNT_W;
   localparam int ENTRY_W   = TRACK_BIT + 1;

   // Configuration registers.
   logic [MASK_W-1:0]   scan_enable_mask_ff;
   logic [THRESH_W-1:0] filter_thresholds_ff;

   // Read stage and memory.
   logic [ENTRY_W-1:0]   state_mem [CHANNELS];
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 s1_valid_ff;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic [CHANNELS-1:0]  entry_valid_ff;

   // Forwarding register of the last write.
   logic                 fwd_valid_ff;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   logic [ENTRY_W-1:0]   fwd_data_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   // Handshake and update signals.
   logic                   req_accept;
   logic                   s1_advance;
   logic                   s1_in_range;
   logic [ADDR_W-1:0]      s1_addr;
   logic [ADDR_W-1:0]      req_addr;
   logic                   mem_we;
   logic [ENTRY_W-1:0]     entry_cur;
   logic [ENTRY_W-1:0]     entry_in;
   logic                   changed_in;

   // Fields of the current entry and their next values.
   logic [VALUE_WIDTH-1:0] sample_v;
   logic [VALUE_WIDTH-1:0] stable_cur;
   logic [VALUE_WIDTH-1:0] cand_cur;
   logic [COUNT_W-1:0]     count_cur;
   logic                   track_cur;
   logic [VALUE_WIDTH-1:0] stable_in;
   logic [VALUE_WIDTH-1:0] cand_in;
   logic [COUNT_W-1:0]     count_in;
   logic                   track_in;
   logic [COUNT_W-1:0]     threshold;
   logic                   enabled;

   // Handshakes: the read stage moves on whenever the output register is free or drains.
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign req_addr   = req_tdata[ADDR_W-1:0];
   assign s1_addr    = s1_channel_ff[ADDR_W-1:0];
   assign s1_in_range = 32'(s1_channel_ff) < CHANNELS;
   assign mem_we     = s1_valid_ff && s1_advance && s1_in_range;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_enable_mask_ff  <= '0;
         filter_thresholds_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCAN_ENABLE_MASK:  scan_enable_mask_ff  <= csr_wdata[MASK_W-1:0];
            CSR_FILTER_THRESHOLDS: filter_thresholds_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State memory: read at acceptance, written back when the word leaves the read stage.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[s1_addr] <= entry_in;
      end
      if (req_accept) begin
         rd_data_ff <= state_mem[req_addr];
      end
   end

   // Read stage control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_channel_ff <= req_tdata[CHANNEL_W-1:0];
         s1_sample_ff  <= req_tdata[CHANNEL_W +: SAMPLE_W];
      end
   end

   // Valid flags per entry and the forwarding register of the last write.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         fwd_valid_ff   <= 1'b0;
      end else if (mem_we) begin
         entry_valid_ff[s1_addr] <= 1'b1;
         fwd_valid_ff            <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= entry_in;
      end
   end

   // Current entry: the last write wins over the memory, and an unwritten entry is zero.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr)) begin
         entry_cur = fwd_data_ff;
      end else if (entry_valid_ff[s1_addr]) begin
         entry_cur = rd_data_ff;
      end else begin
         entry_cur = '0;
      end
   end

   assign stable_cur = entry_cur[STABLE_LO +: VALUE_WIDTH];
   assign cand_cur   = entry_cur[CAND_LO +: VALUE_WIDTH];
   assign count_cur  = entry_cur[COUNT_LO +: COUNT_W];
   assign track_cur  = entry_cur[TRACK_BIT];
   assign sample_v   = s1_sample_ff[VALUE_WIDTH-1:0];
   assign threshold  = filter_thresholds_ff[{s1_channel_ff, 3'b000} +: COUNT_W];
   assign enabled    = scan_enable_mask_ff[s1_channel_ff];

   // Debounce update of one channel.
   always_comb begin
      stable_in  = stable_cur;
      cand_in    = cand_cur;
      count_in   = count_cur;
      track_in   = track_cur;
      changed_in = 1'b0;
      if (enabled && (sample_v != stable_cur)) begin
         if (!track_cur) begin
            // First differing sample starts tracking it as the candidate.
            cand_in  = sample_v;
            count_in = '0;
            track_in = 1'b1;
         end else begin
            if (sample_v == cand_cur) begin
               if (count_cur < COUNT_MAX) begin
                  count_in = count_cur + COUNT_W'(1);
               end
            end else begin
               count_in = '0;
               track_in = 1'b0;
            end
            // The threshold is checked even after a mismatch.
            if (count_in >= threshold) begin
               stable_in  = cand_cur;
               count_in   = '0;
               track_in   = 1'b0;
               changed_in = 1'b1;
            end
         end
      end
   end

   assign entry_in = {track_in, count_in, cand_in, stable_in};

   // Result word; a channel outside the range reports zeros.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[CHANNEL_W-1:0] = s1_channel_ff;
      if (s1_in_range) begin
         rsp_data_in[CHANNEL_W +: SAMPLE_W]  = SAMPLE_W'(stable_in);
         rsp_data_in[CHANNEL_W + SAMPLE_W]     = changed_in;
         rsp_data_in[CHANNEL_W + SAMPLE_W + 1] = track_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/mcpd_checker.sv =====
// Port-level checker of the multi-channel port debouncer and its bind statement.
module mcpd_checker
   import mcpd_pkg::*;
#(
   parameter int CHANNELS = DEF_CHANNELS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Reset empties the output register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // A stalled result word holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // A channel outside the range reports zeros.
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (32'(rsp_tdata[CHANNEL_W-1:0]) >= CHANNELS)
      |-> (rsp_tdata[RSP_TDATA_W-1:CHANNEL_W] == '0))
      else $error("out-of-range channel reported state");

   // A committed change ends tracking.
   a_change_ends_tracking: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[CHANNEL_W + SAMPLE_W] |-> !rsp_tdata[CHANNEL_W + SAMPLE_W + 1])
      else $error("change reported while still tracking");

endmodule

bind multi_channel_port_debouncer mcpd_checker #(
   .CHANNELS (CHANNELS)
) u_mcpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb_multi_channel_port_debouncer.sv =====
// Self-checking testbench for the multi-channel port debouncer stream block.
`timescale 1ns / 1ps

module tb_multi_channel_port_debouncer;
   import mcpd_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASES        = 10;
   localparam int PHASE_WORDS   = 90;
   localparam int SETTLE_CYCLES = 6;

   // One result word, split into its fields.
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  stable;
      logic                 changed;
      logic                 tracking;
   } debounce_result_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR_WRITE
   } row_kind_type;

   // One line of the directed stimulus list.
   typedef struct {
      row_kind_type         kind;
      csr_index_type        index;
      logic [THRESH_W-1:0]  wdata;
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
      bit                   typed;
      debounce_result_type  result;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [THRESH_W-1:0]    csr_wdata = '0;

   // Predictor copy of the registers and the per-channel state.
   logic [MASK_W-1:0]   scan_mask;
   logic [THRESH_W-1:0] filter_limits;
   logic [SAMPLE_W-1:0] debounced_mem [8];
   logic [SAMPLE_W-1:0] candidate_mem [8];
   logic [COUNT_W-1:0]  match_count_mem [8];
   logic                tracking_mem [8];

   debounce_result_type pending_results [$];
   directed_row_type    directed_rows [$];

   int  error_count  = 0;
   int  words_sent   = 0;
   int  words_seen   = 0;
   int  commits_seen = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  tx_idle_on   = 1'b1;
   bit  rx_stall_on  = 1'b1;

   multi_channel_port_debouncer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly short idle gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Debounce update of one channel; returns the word the block should send.
   function automatic debounce_result_type debounce_step(logic [CHANNEL_W-1:0] ch,
                                                         logic [SAMPLE_W-1:0] smp);
      debounce_result_type res;
      logic [COUNT_W-1:0] limit;
      res.channel = ch;
      res.changed = 1'b0;
      limit = filter_limits[int'(ch) * 8 +: 8];
      if (scan_mask[ch] && smp != debounced_mem[ch]) begin
         if (!tracking_mem[ch]) begin
            // A new differing value starts tracking; no threshold check yet.
            candidate_mem[ch]   = smp;
            match_count_mem[ch] = '0;
            tracking_mem[ch]    = 1'b1;
         end else begin
            if (smp == candidate_mem[ch]) begin
               if (match_count_mem[ch] != COUNT_MAX) match_count_mem[ch]++;
            end else begin
               match_count_mem[ch] = '0;
               tracking_mem[ch]    = 1'b0;
            end
            // Checked even after a mismatch, so a zero threshold commits.
            if (match_count_mem[ch] >= limit) begin
               debounced_mem[ch]   = candidate_mem[ch];
               match_count_mem[ch] = '0;
               tracking_mem[ch]    = 1'b0;
               res.changed         = 1'b1;
            end
         end
      end
      res.stable   = debounced_mem[ch];
      res.tracking = tracking_mem[ch];
      return res;
   endfunction

   // Sender: optional idle gap, then hold the word until it is taken.
   task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                              input bit typed, input debounce_result_type typed_res);
      debounce_result_type res;
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - CHANNEL_W - SAMPLE_W){1'b0}}, smp, ch};
      do @(posedge clock); while (!req_tready);
      res = debounce_step(ch, smp);
      pending_results.push_back(typed ? typed_res : res);
      words_sent++;
   endtask

   // Stop sending and wait until every expected word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only issued while the block is idle.
   task automatic write_csr(input csr_index_type idx, input logic [THRESH_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SCAN_ENABLE_MASK:  scan_mask = data[MASK_W-1:0];
         CSR_FILTER_THRESHOLDS: filter_limits = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [MASK_W-1:0] mask,
                                 input logic [THRESH_W-1:0] limits);
      drain();
      write_csr(CSR_SCAN_ENABLE_MASK, {{(THRESH_W - MASK_W){1'b0}}, mask});
      write_csr(CSR_FILTER_THRESHOLDS, limits);
   endtask

   // Thresholds that mostly let values commit within a short burst.
   function automatic logic [THRESH_W-1:0] random_limits();
      logic [THRESH_W-1:0] v;
      for (int b = 0; b < 8; b++) begin
         if ($urandom_range(0, 9) < 8) v[b * 8 +: 8] = 8'($urandom_range(0, 4));
         else v[b * 8 +: 8] = 8'($urandom_range(0, 255));
      end
      return v;
   endfunction

   function automatic directed_row_type sample_row(logic [CHANNEL_W-1:0] ch,
                                                   logic [SAMPLE_W-1:0] smp);
      directed_row_type r;
      r = '{kind: ROW_SAMPLE, index: CSR_SCAN_ENABLE_MASK, wdata: '0, channel: ch,
            sample: smp, typed: 1'b0, result: '0};
      return r;
   endfunction

   function automatic directed_row_type typed_row(logic [CHANNEL_W-1:0] ch,
                                                  logic [SAMPLE_W-1:0] smp,
                                                  logic [SAMPLE_W-1:0] st, logic chg, logic trk);
      directed_row_type r;
      r = sample_row(ch, smp);
      r.typed  = 1'b1;
      r.result = '{channel: ch, stable: st, changed: chg, tracking: trk};
      return r;
   endfunction

   function automatic directed_row_type csr_row(csr_index_type idx, logic [THRESH_W-1:0] data);
      directed_row_type r;
      r = sample_row('0, '0);
      r.kind  = ROW_CSR_WRITE;
      r.index = idx;
      r.wdata = data;
      return r;
   endfunction

   // Receiver back-pressure with its own random stalls.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && rx_stall_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      debounce_result_type got;
      debounce_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.channel  = rsp_tdata[2:0];
         got.stable   = rsp_tdata[10:3];
         got.changed  = rsp_tdata[11];
         got.tracking = rsp_tdata[12];
         words_seen++;
         if (got.changed) commits_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word ch=%0d stable=%02h changed=%0b tracking=%0b",
                     $time, got.channel, got.stable, got.changed, got.tracking);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.channel !== want.channel) begin
               $display("%0t: out_channel expected %0d, got %0d",
                        $time, want.channel, got.channel);
               error_count++;
            end
            if (got.stable !== want.stable) begin
               $display("%0t: debounced value ch%0d expected %02h, got %02h",
                        $time, want.channel, want.stable, got.stable);
               error_count++;
            end
            if (got.changed !== want.changed) begin
               $display("%0t: changed ch%0d expected %0b, got %0b",
                        $time, want.channel, want.changed, got.changed);
               error_count++;
            end
            if (got.tracking !== want.tracking) begin
               $display("%0t: tracking ch%0d expected %0b, got %0b",
                        $time, want.channel, want.tracking, got.tracking);
               error_count++;
            end
         end
      end
   end

   // Main stimulus: reset, directed list, then random phases.
   initial begin
      logic [CHANNEL_W-1:0] ch;
      logic [SAMPLE_W-1:0]  val;
      logic [MASK_W-1:0]    mask;
      logic [THRESH_W-1:0]  limits;
      int                   n;
      int                   len;
      int                   glitch;
      bit                   paused;

      scan_mask     = '0;
      filter_limits = '0;
      for (int i = 0; i < 8; i++) begin
         debounced_mem[i]   = '0;
         candidate_mem[i]   = '0;
         match_count_mem[i] = '0;
         tracking_mem[i]    = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset every channel is disabled and reads as zero.
      directed_rows.push_back(typed_row(3'd0, 8'hFF, 8'h00, 1'b0, 1'b0));
      directed_rows.push_back(typed_row(3'd7, 8'h00, 8'h00, 1'b0, 1'b0));
      // Thresholds: ch0 zero, ch1 two, ch2 maximum, ch7 one, the rest three.
      directed_rows.push_back(csr_row(CSR_SCAN_ENABLE_MASK, 64'hFF));
      directed_rows.push_back(csr_row(CSR_FILTER_THRESHOLDS, 64'h0103_0303_03FF_0200));
      // A zero threshold commits the old candidate on a mismatch.
      directed_rows.push_back(typed_row(3'd0, 8'hAA, 8'h00, 1'b0, 1'b1));
      directed_rows.push_back(typed_row(3'd0, 8'h55, 8'hAA, 1'b1, 1'b0));
      // Normal commit after two matches, then an equal sample.
      directed_rows.push_back(sample_row(3'd1, 8'h0F));
      directed_rows.push_back(sample_row(3'd1, 8'h0F));
      directed_rows.push_back(sample_row(3'd1, 8'h0F));
      directed_rows.push_back(sample_row(3'd1, 8'h0F));
      // An equal sample in the middle keeps tracking; a third value drops it.
      directed_rows.push_back(sample_row(3'd1, 8'hF0));
      directed_rows.push_back(sample_row(3'd1, 8'h0F));
      directed_rows.push_back(sample_row(3'd1, 8'hF0));
      directed_rows.push_back(sample_row(3'd1, 8'h33));
      // Threshold of one on the top channel with an all-ones value.
      directed_rows.push_back(typed_row(3'd7, 8'hFF, 8'h00, 1'b0, 1'b1));
      directed_rows.push_back(typed_row(3'd7, 8'hFF, 8'hFF, 1'b1, 1'b0));
      // Disabling a channel freezes it but keeps its tracking flag.
      directed_rows.push_back(typed_row(3'd3, 8'h80, 8'h00, 1'b0, 1'b1));
      directed_rows.push_back(csr_row(CSR_SCAN_ENABLE_MASK, 64'hF7));
      directed_rows.push_back(typed_row(3'd3, 8'h81, 8'h00, 1'b0, 1'b1));
      directed_rows.push_back(sample_row(3'd2, 8'h01));
      directed_rows.push_back(sample_row(3'd2, 8'h01));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR_WRITE) begin
            drain();
            write_csr(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            send_sample(directed_rows[i].channel, directed_rows[i].sample,
                        directed_rows[i].typed, directed_rows[i].result);
         end
      end

      // Random phases, each under its own register settings.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin mask = 8'hFF; limits = '0; end
            1: begin mask = 8'h00; limits = random_limits(); end
            2: begin mask = 8'hFF; limits = '1; end
            default: begin
               mask   = 8'($urandom) | 8'($urandom);
               limits = random_limits();
            end
         endcase
         apply_settings(mask, limits);
         tx_idle_on  = (p % 3 != 1);
         rx_stall_on = (p % 4 != 2);

         // Long steady run so the counter climbs to its top value and commits.
         if (p == 2) begin
            ch  = 3'($urandom_range(0, 7));
            val = ~debounced_mem[ch];
            for (int i = 0; i < 258; i++) send_sample(ch, val, 1'b0, '0);
         end

         n      = 0;
         paused = 1'b0;
         while (n < PHASE_WORDS) begin
            if (!paused && n >= PHASE_WORDS / 2) begin
               // Hold off the sender until everything in flight has returned.
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
               // Bouncing port: a run of one value, sometimes with a glitch.
               ch     = 3'($urandom_range(0, 7));
               val    = ($urandom_range(0, 7) == 0) ? debounced_mem[ch]
                                                    : 8'($urandom_range(0, 255));
               len    = $urandom_range(1, 8);
               glitch = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
               for (int i = 0; i < len; i++) begin
                  if (i == glitch) send_sample(ch, val ^ 8'($urandom_range(1, 255)), 1'b0, '0);
                  else send_sample(ch, val, 1'b0, '0);
               end
               n += len;
            end else begin
               send_sample(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0, '0);
               n++;
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d sample words over %0d register settings; %0d words checked.",
               words_sent, PHASES + 2, words_seen);
      $display("Commits observed: %0d, including a full-range count to the top threshold.",
               commits_seen);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived.",
                  error_count, pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
